FILE: sv/fit_block_allocator_top_defines.svh
`ifndef FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define FBA_CHECK(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define FBA_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/fba_pkg.sv
`default_nettype none

package fba_pkg;

   localparam int DEF_NUM_BLOCKS = 16;
   localparam int DEF_SIZE_BITS  = 16;

   localparam int OP_BITS         = 1;
   localparam int INDEX_BITS      = 4;
   localparam int SIZE_FIELD_BITS = 16;
   localparam int STATUS_BITS     = 2;
   localparam int MODE_BITS       = 2;
   localparam int COUNT_BITS      = 5;
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;

   localparam logic [OP_BITS-1:0] OP_LOAD  = 1'b0;
   localparam logic [OP_BITS-1:0] OP_ALLOC = 1'b1;

   localparam logic [MODE_BITS-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_BEST  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_WORST = 2'd2;

   localparam logic [MODE_BITS-1:0]  MODE_RESET  = MODE_FIRST;
   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 5'd16;

   localparam logic REG_FIT_MODE    = 1'b0;
   localparam logic REG_BLOCK_COUNT = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_LOADED = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ALLOC  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NOFIT  = 2'd2;

   typedef struct packed {
      logic valid;
      logic found;
   } scan_ctrl_type;

endpackage

`default_nettype wire

FILE: sv/fba_req_if.sv
`default_nettype none

interface fba_req_if;
   import fba_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OP_BITS-1:0]         op;
   logic [INDEX_BITS-1:0]      block_index;
   logic [SIZE_FIELD_BITS-1:0] size;

   modport source (output valid, op, block_index, size, input ready);
   modport sink (input valid, op, block_index, size, output ready);
endinterface

`default_nettype wire

FILE: sv/fba_rsp_if.sv
`default_nettype none

interface fba_rsp_if;
   import fba_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [STATUS_BITS-1:0]     status;
   logic [INDEX_BITS-1:0]      chosen_block;
   logic [SIZE_FIELD_BITS-1:0] leftover;

   modport source (output valid, status, chosen_block, leftover, input ready);
   modport sink (input valid, status, chosen_block, leftover, output ready);
endinterface

`default_nettype wire

FILE: sv/fba_cell.sv
`default_nettype none

module fba_cell #(
   parameter int NUM_BLOCKS = fba_pkg::DEF_NUM_BLOCKS,
   parameter int SIZE_BITS  = fba_pkg::DEF_SIZE_BITS,
   parameter int IDX_BITS   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1,
   parameter int CELL_INDEX = 0
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [fba_pkg::MODE_BITS-1:0]  mode,
   input  wire logic [fba_pkg::COUNT_BITS-1:0] count,
   input  wire logic [SIZE_BITS-1:0]           req_size,
   input  wire logic                           wr_en,
   input  wire logic [IDX_BITS-1:0]            wr_idx,
   input  wire logic [SIZE_BITS-1:0]           wr_data,
   input  wire fba_pkg::scan_ctrl_type         ctrl_i,
   input  wire logic [IDX_BITS-1:0]            pick_i,
   input  wire logic [SIZE_BITS-1:0]           pick_free_i,
   output fba_pkg::scan_ctrl_type              ctrl_o,
   output logic [IDX_BITS-1:0]                 pick_o,
   output logic [SIZE_BITS-1:0]                pick_free_o
);
   import fba_pkg::*;

   logic [SIZE_BITS-1:0] free_ff, free_in;
   scan_ctrl_type        ctrl_ff, ctrl_in;
   logic [IDX_BITS-1:0]  pick_ff, pick_in;
   logic [SIZE_BITS-1:0] pick_free_ff, pick_free_in;
   logic                 active;
   logic                 fits;
   logic                 better;
   logic                 take;

   always_comb begin
      active = 32'(CELL_INDEX) < 32'(count);
      fits   = active && (req_size <= free_ff);
      better = ((mode == MODE_BEST) && (free_ff < pick_free_i)) ||
               ((mode == MODE_WORST) && (free_ff > pick_free_i));
      take   = ctrl_i.valid && fits && (!ctrl_i.found || better);

      ctrl_in.valid = ctrl_i.valid;
      ctrl_in.found = ctrl_i.found || take;
      pick_in       = take ? IDX_BITS'(CELL_INDEX) : pick_i;
      pick_free_in  = take ? free_ff : pick_free_i;

      free_in = (wr_en && (wr_idx == IDX_BITS'(CELL_INDEX))) ? wr_data : free_ff;
   end

   always_ff @(posedge clock) begin
      pick_ff      <= pick_in;
      pick_free_ff <= pick_free_in;
      if (reset) begin
         free_ff <= '0;
         ctrl_ff <= '0;
      end else begin
         free_ff <= free_in;
         ctrl_ff <= ctrl_in;
      end
   end

   assign ctrl_o      = ctrl_ff;
   assign pick_o      = pick_ff;
   assign pick_free_o = pick_free_ff;
endmodule

`default_nettype wire

FILE: sv/fit_block_allocator_top.sv
`default_nettype none
`include "fit_block_allocator_top_defines.svh"

// Free-size table for NUM_BLOCKS memory blocks with first, best or worst fit
// allocation. Each block's free size lives in its own cell of a row, and a
// request walks that row as a token that moves one cell per clock, so an
// allocation passes through the start register, every cell and the finish
// state before its result word is registered, and a load gives its result
// word in the next cycle. One item is in work at a time, and a new item is
// taken only when the output holds no result word or its word leaves in the
// same cycle. Register 0 (byte address 0) holds the fit mode, where the
// unused code acts as first fit, and register 1 (byte address 4) holds the
// number of active blocks, where values above NUM_BLOCKS search every block.
module fit_block_allocator_top #(
   parameter int NUM_BLOCKS = fba_pkg::DEF_NUM_BLOCKS,
   parameter int SIZE_BITS  = fba_pkg::DEF_SIZE_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   fba_req_if.sink                                req_chan,
   fba_rsp_if.source                              rsp_chan,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [fba_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [fba_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [fba_pkg::CSR_DATA_BITS-1:0]      prdata,
   output logic                                   pready
);
   import fba_pkg::*;

   localparam int IDX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                  state_ff, state_in;
   logic [MODE_BITS-1:0]       mode_ff, mode_in;
   logic [COUNT_BITS-1:0]      count_ff, count_in;
   logic                       start_ff, start_in;
   logic [SIZE_BITS-1:0]       size_ff, size_in;
   logic                       found_ff, found_in;
   logic [IDX_BITS-1:0]        pick_ff, pick_in;
   logic [SIZE_BITS-1:0]       pick_free_ff, pick_free_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]     rsp_status_ff, rsp_status_in;
   logic [INDEX_BITS-1:0]      rsp_block_ff, rsp_block_in;
   logic [SIZE_FIELD_BITS-1:0] rsp_left_ff, rsp_left_in;

   scan_ctrl_type        chain_ctrl [NUM_BLOCKS+1];
   logic [IDX_BITS-1:0]  chain_pick [NUM_BLOCKS+1];
   logic [SIZE_BITS-1:0] chain_free [NUM_BLOCKS+1];
   logic [NUM_BLOCKS:0]  chain_valid;

   logic                 csr_write;
   logic                 out_free;
   logic                 req_take;
   logic                 finish_go;
   logic [31:0]          size_wide;
   logic [31:0]          idx_wide;
   logic [31:0]          pick_wide;
   logic [31:0]          left_wide;
   logic                 load_in_range;
   logic [SIZE_BITS-1:0] remain;
   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_idx;
   logic [SIZE_BITS-1:0] wr_data;

   assign chain_ctrl[0] = '{valid: start_ff, found: 1'b0};
   assign chain_pick[0] = '0;
   assign chain_free[0] = '0;

   for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
      fba_cell #(
         .NUM_BLOCKS (NUM_BLOCKS),
         .SIZE_BITS  (SIZE_BITS),
         .IDX_BITS   (IDX_BITS),
         .CELL_INDEX (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .mode        (mode_ff),
         .count       (count_ff),
         .req_size    (size_ff),
         .wr_en       (wr_en),
         .wr_idx      (wr_idx),
         .wr_data     (wr_data),
         .ctrl_i      (chain_ctrl[k]),
         .pick_i      (chain_pick[k]),
         .pick_free_i (chain_free[k]),
         .ctrl_o      (chain_ctrl[k+1]),
         .pick_o      (chain_pick[k+1]),
         .pick_free_o (chain_free[k+1])
      );
   end

   for (genvar k = 0; k <= NUM_BLOCKS; k++) begin : g_valid
      assign chain_valid[k] = chain_ctrl[k].valid;
   end

   always_comb begin
      csr_write = psel && penable && pwrite;
      mode_in   = mode_ff;
      count_in  = count_ff;
      if (csr_write) begin
         unique case (paddr[CSR_ADDR_BITS-1])
            REG_FIT_MODE:    mode_in  = pwdata[MODE_BITS-1:0];
            REG_BLOCK_COUNT: count_in = pwdata[COUNT_BITS-1:0];
            default:         mode_in  = mode_ff;
         endcase
      end
      if (paddr[CSR_ADDR_BITS-1] == REG_BLOCK_COUNT) begin
         prdata = CSR_DATA_BITS'(count_ff);
      end else begin
         prdata = CSR_DATA_BITS'(mode_ff);
      end
   end

   assign pready = 1'b1;

   always_comb begin
      out_free       = !rsp_valid_ff || rsp_chan.ready;
      req_chan.ready = (state_ff == ST_IDLE) && out_free;
      req_take       = req_chan.valid && req_chan.ready;
      finish_go      = (state_ff == ST_FINISH) && out_free;

      size_wide     = 32'(req_chan.size);
      idx_wide      = 32'(req_chan.block_index);
      load_in_range = idx_wide < 32'(NUM_BLOCKS);
      remain        = pick_free_ff - size_ff;
      pick_wide     = 32'(pick_ff);
      left_wide     = 32'(remain);

      if (finish_go && found_ff) begin
         wr_en   = 1'b1;
         wr_idx  = pick_ff;
         wr_data = remain;
      end else begin
         wr_en   = req_take && (req_chan.op == OP_LOAD) && load_in_range;
         wr_idx  = idx_wide[IDX_BITS-1:0];
         wr_data = size_wide[SIZE_BITS-1:0];
      end

      state_in      = state_ff;
      start_in      = 1'b0;
      size_in       = size_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      pick_free_in  = pick_free_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_left_in   = rsp_left_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_chan.op == OP_LOAD) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_LOADED;
                  rsp_block_in  = '0;
                  rsp_left_in   = '0;
               end else begin
                  size_in  = size_wide[SIZE_BITS-1:0];
                  start_in = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (chain_ctrl[NUM_BLOCKS].valid) begin
               found_in     = chain_ctrl[NUM_BLOCKS].found;
               pick_in      = chain_pick[NUM_BLOCKS];
               pick_free_in = chain_free[NUM_BLOCKS];
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (found_ff) begin
                  rsp_status_in = STATUS_ALLOC;
                  rsp_block_in  = pick_wide[INDEX_BITS-1:0];
                  rsp_left_in   = left_wide[SIZE_FIELD_BITS-1:0];
               end else begin
                  rsp_status_in = STATUS_NOFIT;
                  rsp_block_in  = '0;
                  rsp_left_in   = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      found_ff      <= found_in;
      pick_ff       <= pick_in;
      pick_free_ff  <= pick_free_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_left_ff   <= rsp_left_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_RESET;
         count_ff     <= COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.chosen_block = rsp_block_ff;
   assign rsp_chan.leftover     = rsp_left_ff;

   `FBA_CHECK(a_single_token, 1'b1, $onehot0(chain_valid), "More than one scan in the row.")
   `FBA_CHECK(a_scan_end_state, chain_valid[NUM_BLOCKS], state_ff == ST_SCAN, "Scan ended outside scan state.")
   `FBA_CHECK_NEXT(a_request_starts, req_take && (req_chan.op == OP_ALLOC), (state_ff == ST_SCAN) && start_ff, "Request did not start a scan.")
   `FBA_CHECK(a_nofit_zero, rsp_chan.valid && (rsp_chan.status == STATUS_NOFIT), (rsp_chan.chosen_block == '0) && (rsp_chan.leftover == '0), "No-fit word carries data.")
endmodule

`default_nettype wire
